### hdl/mnt_pkg.sv
// Package for the mono note tracker with bend.
// Holds field widths, action codes, the internal op type and the command record.
// No dependencies.
`default_nettype none

package mnt_pkg;

  localparam int ActionW  = 3;
  localparam int NoteW    = 7;
  localparam int WheelW   = 14;
  localparam int CountW   = 8;
  localparam int RangeW   = 5;
  localparam int BendW    = 19;
  localparam int TargetW  = 22;
  localparam int FracW    = 13;
  localparam int NumNotes = 128;

  localparam logic [ActionW-1:0] ActNoteOn  = 3'd0;
  localparam logic [ActionW-1:0] ActNoteOff = 3'd1;
  localparam logic [ActionW-1:0] ActWheel   = 3'd2;
  localparam logic [ActionW-1:0] ActAllOff  = 3'd3;

  localparam logic [RangeW-1:0] RangeMin   = 5'd1;
  localparam logic [RangeW-1:0] RangeMax   = 5'd24;
  localparam logic [RangeW-1:0] RangeReset = 5'd2;

  localparam logic [TargetW-1:0] NoNoteQ13 = 22'h3FE000;

  typedef enum logic [2:0] {
    OP_NOTE_ON,
    OP_NOTE_OFF,
    OP_WHEEL,
    OP_CLEAR,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic [NoteW-1:0]         note;
    logic signed [WheelW-1:0] offset;
  } cmd_t;

endpackage

`default_nettype wire

### hdl/mnt_if.sv
// Valid/ready channel interfaces for the mono note tracker.
// Depends on mnt_pkg for field widths.
`default_nettype none

interface mnt_in_if;
  logic                           valid;
  logic                           ready;
  logic [mnt_pkg::ActionW-1:0]    action;
  logic [mnt_pkg::NoteW-1:0]      note_number;
  logic [mnt_pkg::WheelW-1:0]     wheel_value;

  modport source (output valid, output action, output note_number, output wheel_value,
                  input ready);
  modport sink   (input valid, input action, input note_number, input wheel_value,
                  output ready);
endinterface

interface mnt_out_if;
  logic                                valid;
  logic                                ready;
  logic                                note_valid;
  logic [mnt_pkg::NoteW-1:0]           current_note;
  logic [mnt_pkg::CountW-1:0]          held_count;
  logic signed [mnt_pkg::BendW-1:0]    bend_q13;
  logic signed [mnt_pkg::TargetW-1:0]  target_q13;

  modport source (output valid, output note_valid, output current_note, output held_count,
                  output bend_q13, output target_q13, input ready);
  modport sink   (input valid, input note_valid, input current_note, input held_count,
                  input bend_q13, input target_q13, output ready);
endinterface

`default_nettype wire

### hdl/mnt_front.sv
// Front end: accepts input transfers, classifies them into commands and
// buffers them in a two-entry queue. Depends on mnt_pkg and mnt_in_if.
`default_nettype none

module mnt_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  mnt_in_if.sink            in_i,
  input  wire logic         pop_i,
  output logic              cmd_valid_o,
  output mnt_pkg::cmd_t     cmd_o
);
  import mnt_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  cmd_t       cmd_new;

  always_comb begin
    cmd_new.note   = in_i.note_number;
    cmd_new.offset = $signed({~in_i.wheel_value[WheelW-1], in_i.wheel_value[WheelW-2:0]});
    case (in_i.action)
      ActNoteOn:  cmd_new.op = OP_NOTE_ON;
      ActNoteOff: cmd_new.op = OP_NOTE_OFF;
      ActWheel:   cmd_new.op = OP_WHEEL;
      ActAllOff:  cmd_new.op = OP_CLEAR;
      default:    cmd_new.op = OP_NONE;
    endcase
  end

  assign in_i.ready  = (count_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

### hdl/mnt_back.sv
// Back end: executes commands on the held-note map, current note and bend,
// runs the split highest-note search and drives the output register.
// Depends on mnt_pkg and mnt_out_if.
`default_nettype none

module mnt_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cmd_valid_i,
  input  wire mnt_pkg::cmd_t                 cmd_i,
  output logic                               pop_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [mnt_pkg::RangeW-1:0]    cfg_data_i,
  mnt_out_if.source                          out_o
);
  import mnt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_FALL,
    ST_REPORT
  } state_e;

  localparam int HalfN = NumNotes / 2;
  localparam int HalfW = $clog2(HalfN);

  state_e                    state_q;
  logic [NumNotes-1:0]       map_q;
  logic [CountW-1:0]         total_q;
  logic                      cur_valid_q;
  logic [NoteW-1:0]          cur_q;
  logic signed [BendW-1:0]   bend_q;
  logic [RangeW-1:0]         range_q;
  logic                      hi_found_q, lo_found_q;
  logic [HalfW-1:0]          hi_idx_q, lo_idx_q;
  logic                      out_valid_q;
  logic                      out_note_valid_q;
  logic [NoteW-1:0]          out_note_q;
  logic [CountW-1:0]         out_count_q;
  logic signed [BendW-1:0]   out_bend_q;
  logic signed [TargetW-1:0] out_target_q;

  logic signed [BendW-1:0]   prod;
  logic [TargetW-1:0]        target_d;
  logic [RangeW-1:0]         range_d;
  logic                      held_now;
  logic                      pick_needed;
  logic                      out_free;

  function automatic logic [HalfW-1:0] top_index(input logic [HalfN-1:0] v);
    logic [HalfW-1:0] idx;
    idx = '0;
    for (int i = 0; i < HalfN; i++) begin
      if (v[i]) idx = i[HalfW-1:0];
    end
    return idx;
  endfunction

  assign pop_o       = (state_q == ST_IDLE) && cmd_valid_i;
  assign held_now    = map_q[cmd_i.note];
  assign pick_needed = (cmd_i.op == OP_NOTE_OFF) && held_now && cur_valid_q
                       && (cur_q == cmd_i.note);
  assign out_free    = !out_valid_q || out_o.ready;
  assign prod        = cmd_i.offset * $signed({1'b0, range_q});

  always_comb begin
    if (cfg_data_i < RangeMin) begin
      range_d = RangeMin;
    end else if (cfg_data_i > RangeMax) begin
      range_d = RangeMax;
    end else begin
      range_d = cfg_data_i;
    end
  end

  always_comb begin
    if (cur_valid_q) begin
      target_d = {2'b00, cur_q, {FracW{1'b0}}}
               + {{(TargetW-BendW){bend_q[BendW-1]}}, bend_q};
    end else begin
      target_d = NoNoteQ13;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.note_valid   = out_note_valid_q;
  assign out_o.current_note = out_note_q;
  assign out_o.held_count   = out_count_q;
  assign out_o.bend_q13     = out_bend_q;
  assign out_o.target_q13   = out_target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      map_q            <= '0;
      total_q          <= '0;
      cur_valid_q      <= 1'b0;
      cur_q            <= '0;
      bend_q           <= '0;
      range_q          <= RangeReset;
      hi_found_q       <= 1'b0;
      lo_found_q       <= 1'b0;
      hi_idx_q         <= '0;
      lo_idx_q         <= '0;
      out_valid_q      <= 1'b0;
      out_note_valid_q <= 1'b0;
      out_note_q       <= '0;
      out_count_q      <= '0;
      out_bend_q       <= '0;
      out_target_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        range_q <= range_d;
      end
      if (state_q == ST_REPORT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            state_q <= pick_needed ? ST_PICK : ST_REPORT;
            case (cmd_i.op)
              OP_NOTE_ON: begin
                map_q[cmd_i.note] <= 1'b1;
                if (!held_now) total_q <= total_q + 8'd1;
                cur_valid_q <= 1'b1;
                cur_q       <= cmd_i.note;
              end
              OP_NOTE_OFF: begin
                if (held_now) begin
                  map_q[cmd_i.note] <= 1'b0;
                  total_q           <= total_q - 8'd1;
                end
              end
              OP_WHEEL: begin
                bend_q <= prod;
              end
              OP_CLEAR: begin
                map_q       <= '0;
                total_q     <= '0;
                cur_valid_q <= 1'b0;
                cur_q       <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_PICK: begin
          hi_found_q <= |map_q[NumNotes-1:HalfN];
          lo_found_q <= |map_q[HalfN-1:0];
          hi_idx_q   <= top_index(map_q[NumNotes-1:HalfN]);
          lo_idx_q   <= top_index(map_q[HalfN-1:0]);
          state_q    <= ST_FALL;
        end
        ST_FALL: begin
          if (hi_found_q) begin
            cur_valid_q <= 1'b1;
            cur_q       <= {1'b1, hi_idx_q};
          end else if (lo_found_q) begin
            cur_valid_q <= 1'b1;
            cur_q       <= {1'b0, lo_idx_q};
          end else begin
            cur_valid_q <= 1'b0;
            cur_q       <= '0;
          end
          state_q <= ST_REPORT;
        end
        ST_REPORT: begin
          if (out_free) begin
            out_note_valid_q <= cur_valid_q;
            out_note_q       <= cur_valid_q ? cur_q : '0;
            out_count_q      <= total_q;
            out_bend_q       <= bend_q;
            out_target_q     <= target_d;
            state_q          <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/mono_note_tracker_with_bend_unit.sv
// Top level of the mono note tracker with bend: front end, command queue, back end.
// Depends on mnt_pkg, mnt_if, mnt_front and mnt_back.
//
//   port        dir  handshake          carries
//   in_i        in   valid/ready        action, note_number, wheel_value
//   out_o       out  valid/ready        note_valid, current_note, held_count,
//                                       bend_q13, target_q13
//   cfg_*_i     in   write enable only  bend_range (clamped to 1..24)
//
// Each item yields one result transfer via the back end's idle and report states;
// a note off of the current note adds the highest-held search (pick, fall).
// The back end executes one item at a time; the two-entry queue keeps input
// transfers flowing while it works. Reset clears the held-note map, count,
// current note and bend at once, and sets the range to 2.
// An output stall holds the back end in its report state.
`default_nettype none

module mono_note_tracker_with_bend_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  mnt_in_if.sink                           in_i,
  mnt_out_if.source                        out_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [mnt_pkg::RangeW-1:0]  cfg_data_i
);
  import mnt_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  mnt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pop_i       (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  mnt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

### hdl/mnt_checker.sv
// Port-level checks for the mono note tracker with bend, attached by bind.
// Depends on mnt_pkg.
`default_nettype none

module mnt_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                out_valid_i,
  input wire logic                                out_ready_i,
  input wire logic                                note_valid_i,
  input wire logic [mnt_pkg::NoteW-1:0]           current_note_i,
  input wire logic [mnt_pkg::CountW-1:0]          held_count_i,
  input wire logic signed [mnt_pkg::BendW-1:0]    bend_q13_i,
  input wire logic signed [mnt_pkg::TargetW-1:0]  target_q13_i
);
  import mnt_pkg::*;

  logic [TargetW-1:0] expect_target;
  assign expect_target = {2'b00, current_note_i, {FracW{1'b0}}}
                       + {{(TargetW-BendW){bend_q13_i[BendW-1]}}, bend_q13_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(target_q13_i)
                                   && $stable(held_count_i))
    else $error("result changed while stalled");

  a_no_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !note_valid_i |-> current_note_i == '0 && target_q13_i == NoNoteQ13)
    else $error("no-note result malformed");

  a_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && note_valid_i |-> target_q13_i == expect_target)
    else $error("target does not match note plus bend");

  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> note_valid_i == (held_count_i != '0) && held_count_i <= 8'd128)
    else $error("held count inconsistent with current note");

endmodule

bind mono_note_tracker_with_bend_unit mnt_checker u_mnt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .note_valid_i   (out_o.note_valid),
  .current_note_i (out_o.current_note),
  .held_count_i   (out_o.held_count),
  .bend_q13_i     (out_o.bend_q13),
  .target_q13_i   (out_o.target_q13)
);

`default_nettype wire

### tb/tb_top.sv
// Testbench for mono_note_tracker_with_bend_unit: drives decoded MIDI events and
// range writes, predicts held map, current note and bend, and checks every result.
// Depends on mnt_pkg, mnt_if and the unit itself.
`timescale 1ns / 100ps

module tb_top;
  import mnt_pkg::*;

  localparam logic [ActionW-1:0] ActOther      = 3'd4;
  localparam logic [ActionW-1:0] ActUnusedLast = 3'd7;
  localparam int WheelCenter = 8192;
  localparam int WheelMax    = 16383;
  localparam int LimitCycles = 200000;
  localparam int SettleCycles = 8;

  typedef struct {
    logic               note_valid;
    logic [NoteW-1:0]   current_note;
    logic [CountW-1:0]  held_count;
    logic [BendW-1:0]   bend_q13;
    logic [TargetW-1:0] target_q13;
  } tracker_report_t;

  class note_tracker_sb;
    bit [NumNotes-1:0] held_notes;
    int                held_n;
    bit                cur_valid;
    bit [NoteW-1:0]    cur_note;
    int                bend_val;
    int                range_val;
    tracker_report_t   expected_reports[$];
    int                fails;

    function new();
      held_notes = '0;
      held_n     = 0;
      cur_valid  = 1'b0;
      cur_note   = '0;
      bend_val   = 0;
      range_val  = int'(RangeReset);
      fails      = 0;
    endfunction

    function void set_range(logic [RangeW-1:0] v);
      if (v < RangeMin) range_val = int'(RangeMin);
      else if (v > RangeMax) range_val = int'(RangeMax);
      else range_val = int'(v);
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void apply_event(logic [ActionW-1:0] act, logic [NoteW-1:0] n,
                              logic [WheelW-1:0] w);
      tracker_report_t r;
      int i;
      int tgt;
      case (act)
        ActNoteOn: begin
          if (!held_notes[n]) begin
            held_notes[n] = 1'b1;
            held_n++;
          end
          cur_valid = 1'b1;
          cur_note  = n;
        end
        ActNoteOff: begin
          if (held_notes[n]) begin
            held_notes[n] = 1'b0;
            held_n--;
            if (cur_valid && cur_note == n) begin
              cur_valid = 1'b0;
              cur_note  = '0;
              for (i = NumNotes - 1; i >= 0 && !cur_valid; i--) begin
                if (held_notes[i]) begin
                  cur_valid = 1'b1;
                  cur_note  = i[NoteW-1:0];
                end
              end
            end
          end
        end
        ActWheel: bend_val = (int'(w) - WheelCenter) * range_val;
        ActAllOff: begin
          held_notes = '0;
          held_n     = 0;
          cur_valid  = 1'b0;
          cur_note   = '0;
        end
        default: ;
      endcase
      tgt = (int'(cur_note) << FracW) + bend_val;
      r.note_valid   = cur_valid;
      r.current_note = cur_valid ? cur_note : '0;
      r.held_count   = held_n[CountW-1:0];
      r.bend_q13     = bend_val[BendW-1:0];
      r.target_q13   = cur_valid ? tgt[TargetW-1:0] : NoNoteQ13;
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [TargetW-1:0] exp_v,
                                logic [TargetW-1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
        fails++;
      end
    endfunction

    function void check_report(tracker_report_t got);
      tracker_report_t e;
      if (expected_reports.size() == 0) begin
        $error("result transfer with no event outstanding");
        fails++;
        return;
      end
      e = expected_reports.pop_front();
      compare_field("note_valid", TargetW'(e.note_valid), TargetW'(got.note_valid));
      compare_field("current_note", TargetW'(e.current_note), TargetW'(got.current_note));
      compare_field("held_count", TargetW'(e.held_count), TargetW'(got.held_count));
      compare_field("bend_q13", TargetW'(e.bend_q13), TargetW'(got.bend_q13));
      compare_field("target_q13", e.target_q13, got.target_q13);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [RangeW-1:0] cfg_data;
  int in_idle = 13;
  int out_idle = 13;
  logic [NoteW-1:0] note_pool [6];
  logic [RangeW-1:0] range_steps [5] = '{5'd0, 5'd31, 5'd25, 5'd24, 5'd1};
  note_tracker_sb sb;
  tracker_report_t seen;

  mnt_in_if  in_if ();
  mnt_out_if out_if ();

  mono_note_tracker_with_bend_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= out_idle);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        sb.apply_event(in_if.action, in_if.note_number, in_if.wheel_value);
      if (out_if.valid && out_if.ready) begin
        seen.note_valid   = out_if.note_valid;
        seen.current_note = out_if.current_note;
        seen.held_count   = out_if.held_count;
        seen.bend_q13     = out_if.bend_q13;
        seen.target_q13   = out_if.target_q13;
        sb.check_report(seen);
      end
    end
  end

  initial begin
    repeat (LimitCycles) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  task automatic push_event(input logic [ActionW-1:0] act, input logic [NoteW-1:0] n,
                            input logic [WheelW-1:0] w);
    while ($urandom_range(99) < in_idle) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.note_number <= n;
    in_if.wheel_value <= w;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_range(input logic [RangeW-1:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_range(v);
  endtask

  task automatic random_event();
    logic [ActionW-1:0] act;
    logic [NoteW-1:0]   n;
    logic [WheelW-1:0]  w;
    int r;
    r   = $urandom_range(99);
    n   = NoteW'($urandom_range(127));
    w   = WheelW'($urandom_range(WheelMax));
    act = ActionW'($urandom_range(ActUnusedLast, ActOther));
    if (r < 40) begin
      act = ActNoteOn;
      n   = note_pool[$urandom_range(5)];
    end else if (r < 70) begin
      act = ActNoteOff;
      n   = note_pool[$urandom_range(5)];
    end else if (r < 82) begin
      act = ActWheel;
      case ($urandom_range(7))
        0: w = '0;
        1: w = WheelW'(WheelMax);
        2: w = WheelW'(WheelCenter);
        default: ;
      endcase
    end else if (r < 85) begin
      act = ActAllOff;
    end else if (r < 90) begin
      act = ActNoteOff;
    end else if (r < 94) begin
      act = ActNoteOn;
    end
    push_event(act, n, w);
  endtask

  task automatic fill_and_clear();
    int order [NumNotes];
    int i;
    int j;
    int t;
    for (i = 0; i < NumNotes; i++) order[i] = i;
    for (i = NumNotes - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < NumNotes; i++)
      push_event(ActNoteOn, order[i][NoteW-1:0], WheelW'($urandom_range(WheelMax)));
    push_event(ActOther, NoteW'($urandom_range(127)), WheelW'($urandom_range(WheelMax)));
    push_event(ActNoteOff, order[NumNotes-1][NoteW-1:0], WheelW'($urandom_range(WheelMax)));
    for (i = 0; i < 6; i++)
      push_event(ActNoteOff, NoteW'($urandom_range(127)), WheelW'($urandom_range(WheelMax)));
    push_event(ActAllOff, NoteW'($urandom_range(127)), WheelW'($urandom_range(WheelMax)));
  endtask

  initial begin
    int ph;
    int k;
    sb = new();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_data          <= '0;
    in_if.valid       <= 1'b0;
    in_if.action      <= '0;
    in_if.note_number <= '0;
    in_if.wheel_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_event(ActOther, 7'd0, 14'd0);
    push_event(ActNoteOff, 7'd60, WheelW'(WheelCenter));
    push_event(ActWheel, 7'd127, 14'd0);
    push_event(ActNoteOn, 7'd127, 14'd0);
    push_event(ActNoteOn, 7'd0, WheelW'(WheelMax));
    push_event(ActNoteOn, 7'd0, 14'd0);
    push_event(ActNoteOff, 7'd127, 14'd0);
    push_event(ActWheel, 7'd0, WheelW'(WheelMax));
    push_event(ActNoteOn, 7'd64, 14'd0);
    push_event(ActNoteOn, 7'd100, 14'd0);
    push_event(ActNoteOff, 7'd100, 14'd0);
    push_event(ActNoteOff, 7'd64, 14'd0);
    push_event(ActNoteOff, 7'd0, 14'd0);
    push_event(ActNoteOn, 7'd5, 14'd0);
    for (k = ActOther + 1; k <= ActUnusedLast; k++)
      push_event(k[ActionW-1:0], 7'd127, WheelW'(WheelMax));
    push_event(ActAllOff, 7'd5, 14'd0);
    push_event(ActWheel, 7'd0, WheelW'(WheelCenter));
    push_event(ActNoteOn, 7'd127, WheelW'(WheelMax));
    push_event(ActWheel, 7'd127, 14'd0);

    for (ph = 0; ph < 7; ph++) begin
      if (ph < 5) write_range(range_steps[ph]);
      else write_range(RangeW'($urandom_range(31)));
      in_idle  = (ph == 3) ? 0 : 13;
      out_idle = (ph == 3) ? 0 : 13;
      for (k = 0; k < 6; k++) note_pool[k] = NoteW'($urandom_range(127));
      push_event(ActOther, NoteW'($urandom_range(127)), WheelW'($urandom_range(WheelMax)));
      if (ph == 2) fill_and_clear();
      repeat (45) random_event();
    end

    drain();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
